[design/mbs_pkg.sv]
package mbs_pkg;

	localparam int BYTE_W    = 8;
	localparam int RATE_W    = 9;
	localparam int OUTCOME_W = 2;
	localparam int LIMIT_W   = 16;
	localparam int SKIP_W    = 28;
	localparam int WIN_W     = 24;

	localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 16'd4096;

	localparam logic [BYTE_W-1:0] CHAR_I = 8'h49;
	localparam logic [BYTE_W-1:0] CHAR_D = 8'h44;
	localparam logic [BYTE_W-1:0] CHAR_3 = 8'h33;

	localparam logic [OUTCOME_W-1:0] OUT_FOUND = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_LIMIT = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_EOF   = 2'd2;

	typedef enum logic [3:0] {
		PH_PREFIX = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_SCAN   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              start_of_file;
		logic              end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0]    kbit_rate;
		logic                 found;
		logic [OUTCOME_W-1:0] outcome;
	} res_item_t;

	function automatic logic [RATE_W-1:0] rate_v1(input logic [3:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd1:    r = 9'd32;
			4'd2:    r = 9'd40;
			4'd3:    r = 9'd48;
			4'd4:    r = 9'd56;
			4'd5:    r = 9'd64;
			4'd6:    r = 9'd80;
			4'd7:    r = 9'd96;
			4'd8:    r = 9'd112;
			4'd9:    r = 9'd128;
			4'd10:   r = 9'd160;
			4'd11:   r = 9'd192;
			4'd12:   r = 9'd224;
			4'd13:   r = 9'd256;
			4'd14:   r = 9'd320;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [RATE_W-1:0] rate_v2(input logic [3:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd1:    r = 9'd8;
			4'd2:    r = 9'd16;
			4'd3:    r = 9'd24;
			4'd4:    r = 9'd32;
			4'd5:    r = 9'd40;
			4'd6:    r = 9'd48;
			4'd7:    r = 9'd56;
			4'd8:    r = 9'd64;
			4'd9:    r = 9'd80;
			4'd10:   r = 9'd96;
			4'd11:   r = 9'd112;
			4'd12:   r = 9'd128;
			4'd13:   r = 9'd160;
			4'd14:   r = 9'd192;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic res_item_t make_res(input logic [RATE_W-1:0] rate,
			input logic [OUTCOME_W-1:0] outcome);
		res_item_t r;
		r.kbit_rate = rate;
		r.found     = (outcome == OUT_FOUND);
		r.outcome   = outcome;
		return r;
	endfunction

endpackage

[design/mbs_ifs.sv]
interface mbs_byte_if;
	import mbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              start_of_file;
	logic              end_of_file;

	modport source(output valid, data_byte, start_of_file, end_of_file, input ready);
	modport sink(input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface mbs_result_if;
	import mbs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [RATE_W-1:0]    kbit_rate;
	logic                 found;
	logic [OUTCOME_W-1:0] outcome;

	modport source(output valid, kbit_rate, found, outcome, input ready);
	modport sink(input valid, kbit_rate, found, outcome, output ready);
endinterface

[design/mbs_hdr_decode.sv]
module mbs_hdr_decode (
	input  logic [31:0]                hdr,
	output logic [mbs_pkg::RATE_W-1:0] rate
);
	import mbs_pkg::*;

	logic [1:0] ver;
	logic [1:0] lay;
	logic [3:0] idx;
	logic       sync_ok;
	logic       fields_ok;

	always_comb begin
		ver       = hdr[20:19];
		lay       = hdr[18:17];
		idx       = hdr[15:12];
		sync_ok   = (hdr[31:24] == 8'hFF) && (hdr[23:21] == 3'b111);
		fields_ok = (lay == 2'b01) && (idx != 4'd0) && (idx != 4'd15) && (ver != 2'b01);
		if (!(sync_ok && fields_ok)) begin
			rate = '0;
		end else if (ver == 2'b11) begin
			rate = rate_v1(idx);
		end else begin
			rate = rate_v2(idx);
		end
	end
endmodule

[design/mbs_core.sv]
module mbs_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  mbs_pkg::in_item_t           item,
	input  logic [mbs_pkg::LIMIT_W-1:0] scan_limit,
	output logic                        emit,
	output mbs_pkg::res_item_t          res
);
	import mbs_pkg::*;

	phase_t              phase_q, ph, ph_n;
	logic [3:0]          pos_q, pos, pos_n;
	logic                tag_q, tag, tag_n;
	logic [SKIP_W-1:0]   skip_q, skip, skip_n, skip_dec;
	logic [WIN_W-1:0]    win_q, win, win_n;
	logic [1:0]          fill_q, fill, fill_n;
	logic [LIMIT_W-1:0]  cnt_q, cnt, cnt_n;
	logic [RATE_W-1:0]   pend_q, pend, pend_n;

	logic [LIMIT_W-1:0]  lim;
	logic                full;
	logic [RATE_W-1:0]   feed_rate;
	logic [WIN_W-1:0]    feed_win;
	logic [1:0]          feed_fill;
	logic [LIMIT_W-1:0]  cnt_inc;
	logic [LIMIT_W-1:0]  feed_cnt;
	logic                feed_match;
	logic                feed_limit;
	logic                stop;

	mbs_hdr_decode u_hdr (
		.hdr  ({win, item.data_byte}),
		.rate (feed_rate)
	);

	always_comb begin
		ph   = phase_q;
		pos  = pos_q;
		tag  = tag_q;
		skip = skip_q;
		win  = win_q;
		fill = fill_q;
		cnt  = cnt_q;
		pend = pend_q;
		if (item.start_of_file) begin
			ph   = PH_PREFIX;
			pos  = '0;
			tag  = 1'b0;
			skip = '0;
			win  = '0;
			fill = '0;
			cnt  = '0;
			pend = '0;
		end
	end

	always_comb begin
		lim        = (scan_limit == '0) ? LIMIT_W'(1) : scan_limit;
		full       = (fill == 2'd3);
		feed_win   = {win[WIN_W-BYTE_W-1:0], item.data_byte};
		feed_fill  = full ? fill : fill + 2'd1;
		cnt_inc    = cnt + LIMIT_W'(1);
		feed_match = full && (feed_rate != '0);
		feed_limit = full && (feed_rate == '0) && (cnt_inc >= lim);
		feed_cnt   = (full && (feed_rate == '0)) ? cnt_inc : cnt;
		skip_dec   = (skip != '0) ? skip - SKIP_W'(1) : skip;
	end

	always_comb begin
		ph_n   = ph;
		pos_n  = pos;
		tag_n  = tag;
		skip_n = skip;
		win_n  = win;
		fill_n = fill;
		cnt_n  = cnt;
		pend_n = pend;
		emit   = 1'b0;
		res    = make_res('0, OUT_EOF);
		stop   = 1'b0;
		case (ph)
			PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					ph_n = PH_SCAN;
				end
				if (item.end_of_file) begin
					emit = 1'b1;
					res  = make_res('0, OUT_EOF);
				end
			end
			PH_SCAN: begin
				win_n  = feed_win;
				fill_n = feed_fill;
				cnt_n  = feed_cnt;
				if (feed_match) begin
					emit = 1'b1;
					res  = make_res(feed_rate, OUT_FOUND);
				end else if (feed_limit) begin
					emit = 1'b1;
					res  = make_res('0, OUT_LIMIT);
				end else if (item.end_of_file) begin
					emit = 1'b1;
					res  = make_res('0, OUT_EOF);
				end
			end
			PH_PREFIX: begin
				case (pos)
					4'd0:    tag_n = (item.data_byte == CHAR_I);
					4'd1:    tag_n = tag && (item.data_byte == CHAR_D);
					4'd2:    tag_n = tag && (item.data_byte == CHAR_3);
					default: tag_n = tag;
				endcase
				if (pos >= 4'd6) begin
					skip_n = {skip[SKIP_W-8:0], item.data_byte[6:0]};
				end
				if ((pend == '0) && (cnt < lim)) begin
					win_n  = feed_win;
					fill_n = feed_fill;
					cnt_n  = feed_cnt;
					if (feed_match) begin
						if (!tag_n) begin
							emit = 1'b1;
							res  = make_res(feed_rate, OUT_FOUND);
							stop = 1'b1;
						end else begin
							pend_n = feed_rate;
						end
					end else if (feed_limit && !tag_n) begin
						emit = 1'b1;
						res  = make_res('0, OUT_LIMIT);
						stop = 1'b1;
					end
				end
				if (!stop) begin
					if (pos >= 4'd9) begin
						if (tag_n) begin
							win_n  = '0;
							fill_n = '0;
							cnt_n  = '0;
							pend_n = '0;
							ph_n   = (skip_n != '0) ? PH_SKIP : PH_SCAN;
						end else begin
							skip_n = '0;
							ph_n   = PH_SCAN;
						end
						if (item.end_of_file) begin
							emit = 1'b1;
							res  = make_res('0, OUT_EOF);
						end
					end else begin
						pos_n = pos + 4'd1;
						if (item.end_of_file) begin
							emit = 1'b1;
							if (tag_n && (pend_n != '0)) begin
								res = make_res(pend_n, OUT_FOUND);
							end else if (tag_n && (cnt_n >= lim)) begin
								res = make_res('0, OUT_LIMIT);
							end else begin
								res = make_res('0, OUT_EOF);
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (emit) begin
			ph_n = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= '0;
			tag_q   <= 1'b0;
			skip_q  <= '0;
			win_q   <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
			pend_q  <= '0;
		end else if (fire) begin
			phase_q <= ph_n;
			pos_q   <= pos_n;
			tag_q   <= tag_n;
			skip_q  <= skip_n;
			win_q   <= win_n;
			fill_q  <= fill_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
		end
	end
endmodule

[design/mp3_bitrate_sniffer_top.sv]
// channel  | dir | handshake     | payload
// bytes    | in  | valid / ready | data_byte[7:0], start_of_file, end_of_file
// report   | out | valid / ready | kbit_rate[8:0], found, outcome[1:0]
// cfg      | in  | write enable  | scan_limit_wdata[15:0]
//
// One item per cycle while no waiting result stalls the decode stage: a byte is
// registered, then decoded against the scan state into the result register,
// which drives report.valid. arst_n clears the scan state and sets scan_limit to
// 4096.
// A waiting result stalls the decode stage; one more byte is still taken into the
// input register while the result waits.
module mp3_bitrate_sniffer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	mbs_byte_if.sink                    bytes,
	mbs_result_if.source                report,
	input  logic                        scan_limit_we,
	input  logic [mbs_pkg::LIMIT_W-1:0] scan_limit_wdata
);
	import mbs_pkg::*;

	logic [LIMIT_W-1:0] scan_limit_q;
	logic               s1_valid_q;
	in_item_t           item_s1;
	logic               stage_go;
	logic               fire;
	logic               emit;
	res_item_t          res;
	logic               res_valid_q;
	res_item_t          res_q;

	assign stage_go    = !res_valid_q || report.ready;
	assign fire        = s1_valid_q && stage_go;
	assign bytes.ready = !s1_valid_q || stage_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= SCAN_LIMIT_RST;
		end else if (scan_limit_we) begin
			scan_limit_q <= scan_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			s1_valid_q <= 1'b1;
		end else if (stage_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.data_byte     <= bytes.data_byte;
			item_s1.start_of_file <= bytes.start_of_file;
			item_s1.end_of_file   <= bytes.end_of_file;
		end
	end

	mbs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.scan_limit (scan_limit_q),
		.emit       (emit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= emit;
		end else if (report.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res;
		end
	end

	assign report.valid     = res_valid_q;
	assign report.kbit_rate = res_q.kbit_rate;
	assign report.found     = res_q.found;
	assign report.outcome   = res_q.outcome;

	a_found_matches_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.found == (report.outcome == OUT_FOUND)))
		else $error("found flag disagrees with outcome");

	a_rate_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.found == (report.kbit_rate != '0)))
		else $error("bitrate present without a found header");

	a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !stage_go) |-> !bytes.ready)
		else $error("byte taken while decode stage is stalled");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_valid_q))
		else $error("result raised without a byte in the decode stage");
endmodule
